@@ design/lbswc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbswc_pkg
// Shared types, constants and functions for the LFSR byte scrambler with
// block ones-weight check.
// ----------------------------------------------------------------------------
package lbswc_pkg;

    // lfsr and data widths
    localparam int unsigned LFSR_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'hD000_0001;

    // default block length in bytes
    localparam int unsigned BLOCK_BYTES_DEF = 64;

    // weight limit below which a block is bad
    localparam int unsigned LOW_LIMIT = 8;

    // configuration port
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    typedef logic [APB_ADDR_W-3:0] reg_idx_t;
    localparam reg_idx_t REG_SEED_KEY     = reg_idx_t'(0);
    localparam reg_idx_t REG_WEIGHT_CHECK = reg_idx_t'(1);

    // register reset values
    localparam logic [LFSR_W-1:0] SEED_KEY_RST     = 32'h0000_0001;
    localparam logic              WEIGHT_CHECK_RST = 1'b1;

    // input word
    typedef struct packed {
        logic              first;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } item_t;

    // result word
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              block_close;
        logic              block_bad;
        logic              any_bad;
        logic              last_out;
    } res_t;

    // lfsr state after eight steps plus the keystream byte
    typedef struct packed {
        logic [LFSR_W-1:0] lfsr;
        logic [BYTE_W-1:0] ks;
    } ks_step_t;

    // eight galois steps, top bit of each step shifted in msb first
    function automatic ks_step_t lfsr_step8(input logic [LFSR_W-1:0] start);
        logic [LFSR_W-1:0] v;
        logic [BYTE_W-1:0] k;
        ks_step_t          r;
        v = start;
        k = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            v = (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
            k = {k[BYTE_W-2:0], v[LFSR_W-1]};
        end
        r.lfsr = v;
        r.ks   = k;
        return r;
    endfunction

    // ones count of a byte
    function automatic logic [3:0] popcount8(input logic [BYTE_W-1:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            n = n + {3'b000, b[i]};
        end
        return n;
    endfunction

endpackage

@@ design/lfsr_byte_scrambler_weight_check_core.sv @@
// ----------------------------------------------------------------------------
// lfsr_byte_scrambler_weight_check_core
// XORs each byte with a keystream from a 32-bit galois lfsr and checks the
// ones weight of each output block when the check is enabled.
// ----------------------------------------------------------------------------
// a result is registered in the output word, or in the skid word while the output word is stalled
// throughput: one byte per cycle while the skid word is empty, set by the single lfsr/counter update stage
// a two-word output buffer keeps item_ready high for one stalled result
// reset: lfsr, counters and sticky flag clear, seed_key = 1, weight_check = 1
module lfsr_byte_scrambler_weight_check_core
    import lbswc_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input words
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    // result words
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res
);

    localparam int unsigned CNT_W      = (BLOCK_BYTES > 2) ? $clog2(BLOCK_BYTES) : 1;
    localparam int unsigned SUM_W      = $clog2(BLOCK_BYTES * BYTE_W + 1);
    localparam int unsigned HIGH_LIMIT = (BLOCK_BYTES - 1) * BYTE_W;

    // configuration registers
    logic [LFSR_W-1:0] seed_key_reg;
    logic              weight_check_reg;

    // stream state
    logic [LFSR_W-1:0] lfsr_reg;
    logic [SUM_W-1:0]  ones_sum_reg;
    logic [CNT_W-1:0]  byte_cnt_reg;
    logic              bad_seen_reg;

    // output buffer
    res_t res_reg, res_next;
    res_t skid_reg, skid_next;
    logic res_valid_reg, res_valid_next;
    logic skid_valid_reg, skid_valid_next;

    logic              item_fire;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;
    logic [LFSR_W-1:0] lfsr_start;
    logic [SUM_W-1:0]  sum_start;
    logic [CNT_W-1:0]  cnt_start;
    logic              bad_start;
    ks_step_t          step;
    logic [BYTE_W-1:0] ob;
    logic [SUM_W-1:0]  sum_new;
    logic              blk_end;
    logic              blk_bad;
    res_t              result;

    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register read
    always_comb
    begin
        case (cfg_idx)
            REG_SEED_KEY:     prdata = seed_key_reg;
            REG_WEIGHT_CHECK: prdata = {{(APB_DATA_W-1){1'b0}}, weight_check_reg};
            default:          prdata = '0;
        endcase
    end

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_key_reg     <= SEED_KEY_RST;
            weight_check_reg <= WEIGHT_CHECK_RST;
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == REG_SEED_KEY)
            begin
                seed_key_reg <= pwdata;
            end
            if (cfg_idx == REG_WEIGHT_CHECK)
            begin
                weight_check_reg <= pwdata[0];
            end
        end
    end

    assign item_ready = ~skid_valid_reg;
    assign item_fire  = item_valid & item_ready;

    // first byte restarts the lfsr and the block counters
    assign lfsr_start = item.first ? seed_key_reg : lfsr_reg;
    assign sum_start  = item.first ? '0 : ones_sum_reg;
    assign cnt_start  = item.first ? '0 : byte_cnt_reg;
    assign bad_start  = item.first ? 1'b0 : bad_seen_reg;

    // keystream and weight
    assign step    = lfsr_step8(lfsr_start);
    assign ob      = item.data_byte ^ step.ks;
    assign sum_new = sum_start + SUM_W'(popcount8(ob));
    assign blk_end = (cnt_start == CNT_W'(BLOCK_BYTES - 1)) | item.last;
    assign blk_bad = blk_end & weight_check_reg &
                     ((sum_new < SUM_W'(LOW_LIMIT)) | (sum_new > SUM_W'(HIGH_LIMIT)));

    always_comb
    begin
        result.out_byte    = ob;
        result.block_close = blk_end;
        result.block_bad   = blk_bad;
        result.any_bad     = bad_start | blk_bad;
        result.last_out    = item.last;
    end

    // stream state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg     <= '0;
            ones_sum_reg <= '0;
            byte_cnt_reg <= '0;
            bad_seen_reg <= 1'b0;
        end
        else if (item_fire)
        begin
            lfsr_reg     <= step.lfsr;
            ones_sum_reg <= blk_end ? '0 : sum_new;
            byte_cnt_reg <= blk_end ? '0 : cnt_start + CNT_W'(1);
            bad_seen_reg <= bad_start | blk_bad;
        end
    end

    // output register with one skid word
    always_comb
    begin
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!res_valid_reg || res_ready)
        begin
            if (skid_valid_reg)
            begin
                res_next        = skid_reg;
                res_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                res_valid_next = item_fire;
                if (item_fire)
                begin
                    res_next = result;
                end
            end
        end
        else if (item_fire)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ design/lbswc_checker.sv @@
// ----------------------------------------------------------------------------
// lbswc_checker
// Port-level checks for the LFSR byte scrambler, bound to the top level.
// ----------------------------------------------------------------------------
module lbswc_checker
    import lbswc_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  item_valid,
    input logic  item_ready,
    input logic  res_valid,
    input logic  res_ready,
    input res_t  res
);

    // a bad flag only shows on a word that closes a block
    a_bad_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.block_bad) |-> res.block_close)
        else $error("block_bad without block_close");

    // a bad block always sets the sticky flag
    a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.block_bad) |-> res.any_bad)
        else $error("block_bad without any_bad");

    // a result appears only after a word was taken in
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(item_valid && item_ready))
        else $error("result word without accepted input word");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("stalled result word changed");

endmodule

bind lfsr_byte_scrambler_weight_check_core lbswc_checker u_lbswc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
);
